@@ rtl/srlc_pkg.sv @@
// Shared types and constants for the segment register load check block.
package srlc_pkg;

   localparam int unsigned SEG_COUNT = 6;

   localparam logic [2:0] SEG_CS = 3'd1;
   localparam logic [2:0] SEG_SS = 3'd2;

   localparam logic [2:0] CSR_PROTECTED_ENABLE   = 3'd0;
   localparam logic [2:0] CSR_VM86_MODE          = 3'd1;
   localparam logic [2:0] CSR_GLOBAL_TABLE_BASE  = 3'd2;
   localparam logic [2:0] CSR_GLOBAL_TABLE_LIMIT = 3'd3;
   localparam logic [2:0] CSR_LOCAL_TABLE_BASE   = 3'd4;
   localparam logic [2:0] CSR_LOCAL_TABLE_LIMIT  = 3'd5;

   typedef enum logic [1:0] {
      FAULT_NONE  = 2'd0,
      FAULT_GP    = 2'd1,
      FAULT_NP    = 2'd2,
      FAULT_ABORT = 2'd3
   } fault_kind_type;

   localparam logic [4:0] TYPE_DATA_FIRST        = 5'h10;
   localparam logic [4:0] TYPE_DATA_LAST         = 5'h17;
   localparam logic [4:0] TYPE_STACK_RW          = 5'h12;
   localparam logic [4:0] TYPE_STACK_RW_ACC      = 5'h13;
   localparam logic [4:0] TYPE_STACK_RW_DOWN     = 5'h16;
   localparam logic [4:0] TYPE_STACK_RW_DOWN_ACC = 5'h17;
   localparam logic [4:0] TYPE_CODE_READ         = 5'h1A;
   localparam logic [4:0] TYPE_CODE_READ_ACC     = 5'h1B;
   localparam logic [4:0] TYPE_CODE_CONF_READ    = 5'h1E;
   localparam logic [4:0] TYPE_CODE_CONF_READ_ACC = 5'h1F;

   localparam int unsigned ACCESS_PRESENT_BIT = 7;
   localparam int unsigned ACCESS_SIZE_BIT    = 14;
   localparam int unsigned ACCESS_GRAN_BIT    = 15;

   localparam logic [15:0] REAL_ACCESS_CLEAR = 16'h4060;
   localparam logic [31:0] REAL_LIMIT        = 32'h0000_FFFF;
   localparam logic [15:0] GLOBAL_LIMIT_RESET = 16'hFFFF;

endpackage

@@ rtl/segment_register_load_check.sv @@
// Top level of the segment register load check block.
//
// Each request transaction loads one segment register (ES, CS, SS, DS, FS, GS)
// from a selector and the two descriptor words fetched for it. Each request
// produces exactly one response transaction with the fault status, the
// descriptor address, the values now held for that register, the accessed
// byte write-back and the current privilege level and size flags.
// The request is captured in an input register; the checks and the descriptor
// decode work on the request held there, and the register file update happens
// at the same edge at which the response is loaded into the output register.
// One request is accepted per cycle for as long as the response side keeps up;
// the rate is set by the single read-modify-write of the segment register file.
// While the response is stalled, the output register holds and a request
// waiting in the input register holds too; req_stall then goes high.
// The csr_ port writes the mode and table registers; the user must write it only
// while no transaction is in flight, as the block itself does not enforce this.
// Reset empties both stages and restores the segment file to base zero,
// limit 0xFFFF and access zero, privilege level zero and 16-bit sizes.
module segment_register_load_check
   import srlc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_seg_index,
   input  logic [15:0] req_selector,
   input  logic [31:0] req_desc_low,
   input  logic [31:0] req_desc_high,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_fault_kind,
   output logic [15:0] rsp_error_code,
   output logic [31:0] rsp_descriptor_address,
   output logic [31:0] rsp_new_base,
   output logic [31:0] rsp_new_limit,
   output logic [15:0] rsp_new_access,
   output logic        rsp_accessed_write,
   output logic [7:0]  rsp_accessed_byte,
   output logic [1:0]  rsp_privilege_level,
   output logic        rsp_stack_is_32,
   output logic        rsp_code_is_32
);

   // Mode and table registers.
   logic        protected_enable_ff;
   logic        vm86_mode_ff;
   logic [31:0] global_table_base_ff;
   logic [15:0] global_table_limit_ff;
   logic [31:0] local_table_base_ff;
   logic [31:0] local_table_limit_ff;

   // Segment register file and processor state.
   logic [31:0] base_ff   [SEG_COUNT];
   logic [31:0] limit_ff  [SEG_COUNT];
   logic [15:0] access_ff [SEG_COUNT];
   logic [1:0]  cpl_ff;
   logic        stack_wide_ff;
   logic        code_wide_ff;

   // Input stage.
   logic        in_valid_ff;
   logic [2:0]  in_seg_ff;
   logic [15:0] in_sel_ff;
   logic [31:0] in_lo_ff;
   logic [31:0] in_hi_ff;

   // Output stage.
   logic           rsp_valid_ff;
   fault_kind_type fault_ff;
   logic [15:0]    err_ff;
   logic [31:0]    daddr_ff;
   logic [31:0]    nbase_ff;
   logic [31:0]    nlimit_ff;
   logic [15:0]    naccess_ff;
   logic           awrite_ff;
   logic [7:0]     abyte_ff;
   logic [1:0]     cpl_out_ff;
   logic           sw_out_ff;
   logic           cw_out_ff;

   logic out_ready;
   logic advance;
   logic req_take;

   // Combinational results for the transaction in the input stage.
   fault_kind_type fault_in;
   logic [15:0]    err_in;
   logic [31:0]    daddr_in;
   logic [31:0]    nbase_in;
   logic [31:0]    nlimit_in;
   logic [15:0]    naccess_in;
   logic           awrite_in;
   logic [7:0]     abyte_in;
   logic [1:0]     cpl_in;
   logic           stack_wide_in;
   logic           code_wide_in;
   logic           seg_write_in;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      logic        seg_ok;
      logic        prot;
      logic [31:0] cur_base;
      logic [31:0] cur_limit;
      logic [15:0] cur_access;
      logic [31:0] tlim;
      logic [31:0] tbase;
      logic        over;
      logic [15:0] offs;
      logic        offs_zero;
      logic [15:0] acc;
      logic [4:0]  dtype;
      logic [1:0]  dpl;
      logic [1:0]  rpl;
      logic        present;
      logic [31:0] dbase;
      logic [19:0] dlim20;
      logic [31:0] dlim;
      logic [15:0] dacc;
      logic        load;
      logic        data_ok;

      seg_ok     = in_seg_ff < 3'(SEG_COUNT);
      prot       = protected_enable_ff && !vm86_mode_ff;
      cur_base   = seg_ok ? base_ff[in_seg_ff]   : '0;
      cur_limit  = seg_ok ? limit_ff[in_seg_ff]  : '0;
      cur_access = seg_ok ? access_ff[in_seg_ff] : '0;

      tlim  = in_sel_ff[2] ? local_table_limit_ff : {16'b0, global_table_limit_ff};
      tbase = in_sel_ff[2] ? local_table_base_ff  : global_table_base_ff;
      over  = {16'b0, in_sel_ff | 16'h0007} > tlim;
      offs      = {in_sel_ff[15:2], 2'b00};
      offs_zero = in_sel_ff[15:2] == '0;

      acc     = in_hi_ff[23:8];
      dtype   = acc[4:0];
      dpl     = acc[6:5];
      rpl     = in_sel_ff[1:0];
      present = acc[ACCESS_PRESENT_BIT];

      dbase  = {in_hi_ff[31:24], in_hi_ff[7:0], in_lo_ff[31:16]};
      dlim20 = {in_hi_ff[19:16], in_lo_ff[15:0]};
      dlim   = acc[ACCESS_GRAN_BIT] ? {dlim20, 12'hFFF} : {12'b0, dlim20};
      dacc   = acc | 16'h0001;

      data_ok = 1'b0;
      load    = 1'b0;

      fault_in      = FAULT_NONE;
      err_in        = '0;
      daddr_in      = '0;
      nbase_in      = cur_base;
      nlimit_in     = cur_limit;
      naccess_in    = cur_access;
      awrite_in     = 1'b0;
      abyte_in      = '0;
      cpl_in        = cpl_ff;
      stack_wide_in = stack_wide_ff;
      code_wide_in  = code_wide_ff;
      seg_write_in  = 1'b0;

      if (seg_ok) begin
         if (!prot) begin
            seg_write_in = 1'b1;
            nbase_in     = {12'b0, in_sel_ff, 4'b0000};
            nlimit_in    = REAL_LIMIT;
            naccess_in   = cur_access & ~REAL_ACCESS_CLEAR;
            if (in_seg_ff == SEG_CS) begin
               code_wide_in = 1'b0;
            end else if (in_seg_ff == SEG_SS) begin
               stack_wide_in = 1'b0;
            end
         end else begin
            daddr_in = {16'b0, in_sel_ff[15:3], 3'b000} + tbase;
            case (in_seg_ff)
               SEG_CS: begin
                  if (over) begin
                     fault_in = FAULT_ABORT;
                  end else begin
                     load = 1'b1;
                  end
               end
               SEG_SS: begin
                  if (offs_zero) begin
                     fault_in = FAULT_GP;
                  end else if (over || cpl_ff != rpl || cpl_ff != dpl) begin
                     fault_in = FAULT_GP;
                     err_in   = offs;
                  end else if (!(dtype inside {TYPE_STACK_RW, TYPE_STACK_RW_ACC,
                                               TYPE_STACK_RW_DOWN, TYPE_STACK_RW_DOWN_ACC})
                               || !present) begin
                     fault_in = FAULT_GP;
                     err_in   = offs;
                  end else begin
                     load = 1'b1;
                  end
               end
               default: begin
                  if (offs_zero) begin
                     seg_write_in = 1'b1;
                     nbase_in     = '0;
                     nlimit_in    = '0;
                     naccess_in   = '0;
                  end else if (over) begin
                     fault_in = FAULT_GP;
                     err_in   = offs;
                  end else begin
                     if (dtype inside {[TYPE_DATA_FIRST:TYPE_DATA_LAST], TYPE_CODE_READ,
                                       TYPE_CODE_READ_ACC}) begin
                        data_ok = dpl >= cpl_ff && dpl >= rpl;
                     end else begin
                        data_ok = dtype inside {TYPE_CODE_CONF_READ, TYPE_CODE_CONF_READ_ACC};
                     end
                     if (!data_ok) begin
                        fault_in = FAULT_GP;
                        err_in   = offs;
                     end else if (!present) begin
                        fault_in = FAULT_NP;
                        err_in   = offs;
                     end else begin
                        load = 1'b1;
                     end
                  end
               end
            endcase

            if (load) begin
               seg_write_in = 1'b1;
               nbase_in     = dbase;
               nlimit_in    = dlim;
               naccess_in   = dacc;
               awrite_in    = 1'b1;
               abyte_in     = dacc[7:0];
               if (in_seg_ff == SEG_CS) begin
                  code_wide_in = dacc[ACCESS_SIZE_BIT];
                  cpl_in       = rpl;
               end else if (in_seg_ff == SEG_SS) begin
                  stack_wide_in = dacc[ACCESS_SIZE_BIT];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         protected_enable_ff  <= 1'b0;
         vm86_mode_ff         <= 1'b0;
         global_table_base_ff <= '0;
         global_table_limit_ff <= GLOBAL_LIMIT_RESET;
         local_table_base_ff  <= '0;
         local_table_limit_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PROTECTED_ENABLE:   protected_enable_ff   <= csr_data[0];
            CSR_VM86_MODE:          vm86_mode_ff          <= csr_data[0];
            CSR_GLOBAL_TABLE_BASE:  global_table_base_ff  <= csr_data;
            CSR_GLOBAL_TABLE_LIMIT: global_table_limit_ff <= csr_data[15:0];
            CSR_LOCAL_TABLE_BASE:   local_table_base_ff   <= csr_data;
            CSR_LOCAL_TABLE_LIMIT:  local_table_limit_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SEG_COUNT; i++) begin
            base_ff[i]   <= '0;
            limit_ff[i]  <= REAL_LIMIT;
            access_ff[i] <= '0;
         end
         cpl_ff        <= '0;
         stack_wide_ff <= 1'b0;
         code_wide_ff  <= 1'b0;
      end else if (advance) begin
         if (seg_write_in) begin
            base_ff[in_seg_ff]   <= nbase_in;
            limit_ff[in_seg_ff]  <= nlimit_in;
            access_ff[in_seg_ff] <= naccess_in;
         end
         cpl_ff        <= cpl_in;
         stack_wide_ff <= stack_wide_in;
         code_wide_ff  <= code_wide_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_seg_ff <= req_seg_index;
         in_sel_ff <= req_selector;
         in_lo_ff  <= req_desc_low;
         in_hi_ff  <= req_desc_high;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fault_ff   <= fault_in;
         err_ff     <= err_in;
         daddr_ff   <= daddr_in;
         nbase_ff   <= nbase_in;
         nlimit_ff  <= nlimit_in;
         naccess_ff <= naccess_in;
         awrite_ff  <= awrite_in;
         abyte_ff   <= abyte_in;
         cpl_out_ff <= cpl_in;
         sw_out_ff  <= stack_wide_in;
         cw_out_ff  <= code_wide_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_fault_kind         = fault_ff;
   assign rsp_error_code         = err_ff;
   assign rsp_descriptor_address = daddr_ff;
   assign rsp_new_base           = nbase_ff;
   assign rsp_new_limit          = nlimit_ff;
   assign rsp_new_access         = naccess_ff;
   assign rsp_accessed_write     = awrite_ff;
   assign rsp_accessed_byte      = abyte_ff;
   assign rsp_privilege_level    = cpl_out_ff;
   assign rsp_stack_is_32        = sw_out_ff;
   assign rsp_code_is_32         = cw_out_ff;

endmodule

@@ rtl/srlc_checker.sv @@
// Port-level checker for the segment register load check block, with its bind.
module srlc_checker
   import srlc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_fault_kind,
   input logic [15:0] rsp_error_code,
   input logic [31:0] rsp_new_base,
   input logic [31:0] rsp_new_limit,
   input logic [15:0] rsp_new_access,
   input logic        rsp_accessed_write,
   input logic [7:0]  rsp_accessed_byte
);

   // A stalled response transaction stays valid and keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fault_kind)
         && $stable(rsp_error_code) && $stable(rsp_new_base)
         && $stable(rsp_new_limit) && $stable(rsp_new_access))
      else $error("stalled response changed");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Without a fault there is no error code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault_kind == FAULT_NONE |-> rsp_error_code == '0)
      else $error("error code without fault");

   // A write-back only happens for a successful load, and carries the accessed bit
   // that the held access value also shows.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accessed_write |-> rsp_fault_kind == FAULT_NONE
         && rsp_accessed_byte[0] && rsp_new_access[0]
         && rsp_accessed_byte == rsp_new_access[7:0])
      else $error("inconsistent accessed write-back");

   // No write-back means a zero accessed byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accessed_write |-> rsp_accessed_byte == '0)
      else $error("accessed byte without write-back");

endmodule

bind segment_register_load_check srlc_checker u_srlc_checker (.*);
